[rtl/mhcc_pkg.sv]
// ----------------------------------------------------------------------------
// mhcc_pkg
// Shared types and constants for the magic hash collision counter.
// ----------------------------------------------------------------------------
package mhcc_pkg;

    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int SHIFT_POS = 58;
    localparam int SHIFT_W   = 6;
    localparam int COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Epoch tag kept beside each slot; epoch zero is never current.
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_HASH1  = 6'b000100,
        ST_HASH2  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

endpackage

[rtl/mhcc_hash.sv]
// ----------------------------------------------------------------------------
// mhcc_hash
// Two-stage multiply-shift hash: 64x64 low product from three 32x32
// partial products, then shift by magic[63:58] and slot index extraction.
// ----------------------------------------------------------------------------
module mhcc_hash #(
    parameter int TABLE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          in_valid,
    input  logic [mhcc_pkg::WORD_W-1:0]   occupancy,
    input  logic [mhcc_pkg::WORD_W-1:0]   magic_word,
    output logic [TABLE_BITS-1:0]         slot_index,
    output logic                          shift_error
);

    localparam logic [mhcc_pkg::SHIFT_W:0] MIN_SHIFT =
        (mhcc_pkg::SHIFT_W+1)'(mhcc_pkg::WORD_W - TABLE_BITS);

    logic [mhcc_pkg::WORD_W-1:0]  mul_ll;
    logic [mhcc_pkg::WORD_W-1:0]  mul_lh;
    logic [mhcc_pkg::WORD_W-1:0]  mul_hl;

    logic [mhcc_pkg::WORD_W-1:0]  pp_ll_reg;
    logic [mhcc_pkg::HALF_W-1:0]  pp_lh_reg;
    logic [mhcc_pkg::HALF_W-1:0]  pp_hl_reg;
    logic [mhcc_pkg::SHIFT_W-1:0] shift_reg;

    logic [mhcc_pkg::HALF_W-1:0]  cross_sum;
    logic [mhcc_pkg::WORD_W-1:0]  product;
    logic [mhcc_pkg::WORD_W-1:0]  shifted;

    logic [TABLE_BITS-1:0]        index_reg;
    logic                         bad_reg;

    // stage 1: partial products (only low half of the cross terms matters)
    assign mul_ll = magic_word[mhcc_pkg::HALF_W-1:0] * occupancy[mhcc_pkg::HALF_W-1:0];
    assign mul_lh = magic_word[mhcc_pkg::WORD_W-1:mhcc_pkg::HALF_W]
                  * occupancy[mhcc_pkg::HALF_W-1:0];
    assign mul_hl = magic_word[mhcc_pkg::HALF_W-1:0]
                  * occupancy[mhcc_pkg::WORD_W-1:mhcc_pkg::HALF_W];

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            pp_ll_reg <= mul_ll;
            pp_lh_reg <= mul_lh[mhcc_pkg::HALF_W-1:0];
            pp_hl_reg <= mul_hl[mhcc_pkg::HALF_W-1:0];
            shift_reg <= magic_word[mhcc_pkg::SHIFT_POS +: mhcc_pkg::SHIFT_W];
        end
    end

    // stage 2: sum, shift, index
    assign cross_sum = pp_lh_reg + pp_hl_reg;
    assign product   = pp_ll_reg + {cross_sum, {mhcc_pkg::HALF_W{1'b0}}};
    assign shifted   = product >> shift_reg;

    always_ff @(posedge aclk) begin
        index_reg <= shifted[TABLE_BITS-1:0];
        bad_reg   <= ({1'b0, shift_reg} < MIN_SHIFT);
    end

    assign slot_index  = index_reg;
    assign shift_error = bad_reg;

endmodule

[rtl/magic_hash_collision_counter_top.sv]
// ----------------------------------------------------------------------------
// magic_hash_collision_counter_top
// Scores a candidate magic multiplier: hashes (occupancy, attack) pairs into
// a slot table and counts slots hit by differing attack sets.
// ----------------------------------------------------------------------------
// Pairs: one is taken only in IDLE, then passes HASH1, HASH2 and UPDATE (multiply,
//   shift, table read, write-back) before the next; a pair marked last also passes
//   EMIT, which loads the result once the output register is free.
// Reset: synchronous, active low; afterwards all 2^TABLE_BITS slots (4096 by
//   default) are swept before the first pair is taken. The same sweep runs after
//   every 255th evaluation when the epoch wraps.
// ----------------------------------------------------------------------------
module magic_hash_collision_counter_top #(
    parameter int TABLE_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // configuration: magic_word
    input  logic                          cfg_wr_en,
    input  logic [mhcc_pkg::WORD_W-1:0]   cfg_wr_data,

    // input pairs
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [2*mhcc_pkg::WORD_W-1:0] s_tdata,   // [63:0] occupancy, [127:64] attack_set
    input  logic                          s_tlast,   // last_entry

    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mhcc_pkg::COUNT_W-1:0]  m_tdata,   // [15:0] collision_count
    output logic                          m_tuser    // [0] shift_error
);

    localparam int DEPTH  = 1 << TABLE_BITS;
    localparam int SLOT_W = mhcc_pkg::EPOCH_W + mhcc_pkg::WORD_W;

    // ------------------------------------------------------------------
    // Control and running state
    // ------------------------------------------------------------------
    mhcc_pkg::state_t state_reg, state_next;

    logic [mhcc_pkg::WORD_W-1:0]  magic_reg;
    logic [mhcc_pkg::EPOCH_W-1:0] epoch_reg,  epoch_next;
    logic [TABLE_BITS-1:0]        clr_addr_reg, clr_addr_next;
    logic [mhcc_pkg::COUNT_W-1:0] count_reg,  count_next;
    logic                         err_reg,    err_next;

    // pair held while it works through the table
    logic [mhcc_pkg::WORD_W-1:0]  att_reg;
    logic                         last_reg;

    // output register: parts the result channel from the pair path
    logic                         m_valid_reg, m_valid_next;
    logic [mhcc_pkg::COUNT_W-1:0] m_data_reg,  m_data_next;
    logic                         m_user_reg,  m_user_next;

    logic                         in_xfer;
    logic                         out_free;

    // hash unit
    logic [TABLE_BITS-1:0]        slot_index;
    logic                         shift_error;

    // slot memory: {epoch tag, attack set}; a slot is filled only when its
    // tag equals the current epoch
    logic [SLOT_W-1:0]            slot_mem [DEPTH];
    logic [SLOT_W-1:0]            rd_word_reg;
    logic                         mem_we;
    logic [TABLE_BITS-1:0]        mem_waddr;
    logic [SLOT_W-1:0]            mem_wdata;
    logic                         mem_re;

    logic [mhcc_pkg::EPOCH_W-1:0] rd_tag;
    logic [mhcc_pkg::WORD_W-1:0]  rd_att;
    logic                         slot_hit;

    assign s_tready = (state_reg == mhcc_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // ------------------------------------------------------------------
    // Hash pipeline: fed on the transfer; partial products, then index registered, index ready later
    // ------------------------------------------------------------------
    mhcc_hash #(
        .TABLE_BITS (TABLE_BITS)
    ) u_hash (
        .aclk        (aclk),
        .in_valid    (in_xfer),
        .occupancy   (s_tdata[mhcc_pkg::WORD_W-1:0]),
        .magic_word  (magic_reg),
        .slot_index  (slot_index),
        .shift_error (shift_error)
    );

    // ------------------------------------------------------------------
    // Slot memory, one write and one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_word_reg <= slot_mem[slot_index];
        end
    end

    assign rd_tag   = rd_word_reg[mhcc_pkg::WORD_W +: mhcc_pkg::EPOCH_W];
    assign rd_att   = rd_word_reg[mhcc_pkg::WORD_W-1:0];
    assign slot_hit = (rd_tag == epoch_reg);

    // read is issued once the index leaves the hash unit
    assign mem_re = (state_reg == mhcc_pkg::ST_HASH2);

    // slot index is stable from HASH2 through UPDATE (hash stage 2 only
    // reloads from stage 1, which holds while no new pair is taken)
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = slot_index;
        mem_wdata = {epoch_reg, att_reg};
        if (state_reg == mhcc_pkg::ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = {mhcc_pkg::EPOCH_STALE, {mhcc_pkg::WORD_W{1'b0}}};
        end else if (state_reg == mhcc_pkg::ST_UPDATE) begin
            // empty slot takes the attack set
            mem_we = !shift_error && !slot_hit;
        end
    end

    // ------------------------------------------------------------------
    // Payload capture
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            att_reg  <= s_tdata[2*mhcc_pkg::WORD_W-1:mhcc_pkg::WORD_W];
            last_reg <= s_tlast;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        clr_addr_next = clr_addr_reg;
        count_next    = count_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        case (state_reg)
            mhcc_pkg::ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + TABLE_BITS'(1);
                if (clr_addr_reg == {TABLE_BITS{1'b1}}) begin
                    state_next = mhcc_pkg::ST_IDLE;
                end
            end
            mhcc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = mhcc_pkg::ST_HASH1;
                end
            end
            mhcc_pkg::ST_HASH1: begin
                state_next = mhcc_pkg::ST_HASH2;
            end
            mhcc_pkg::ST_HASH2: begin
                state_next = mhcc_pkg::ST_UPDATE;
            end
            mhcc_pkg::ST_UPDATE: begin
                if (shift_error) begin
                    err_next = 1'b1;
                end else if (slot_hit && (rd_att != att_reg)
                             && (count_reg != mhcc_pkg::COUNT_MAX)) begin
                    count_next = count_reg + mhcc_pkg::COUNT_W'(1);
                end
                state_next = last_reg ? mhcc_pkg::ST_EMIT : mhcc_pkg::ST_IDLE;
            end
            mhcc_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = count_reg;
                    m_user_next  = err_reg;
                    count_next   = '0;
                    err_next     = 1'b0;
                    // new epoch empties the table; sweep when tags run out
                    if (epoch_reg == mhcc_pkg::EPOCH_LAST) begin
                        epoch_next    = mhcc_pkg::EPOCH_FIRST;
                        clr_addr_next = '0;
                        state_next    = mhcc_pkg::ST_CLEAR;
                    end else begin
                        epoch_next = epoch_reg + mhcc_pkg::EPOCH_W'(1);
                        state_next = mhcc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next    = mhcc_pkg::ST_CLEAR;
                clr_addr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mhcc_pkg::ST_CLEAR;
            epoch_reg    <= mhcc_pkg::EPOCH_FIRST;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            err_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            magic_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            err_reg      <= err_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                magic_reg <= cfg_wr_data;
            end
        end
    end

endmodule
